>>> src/utf8d_pkg.sv
// Shared widths, continuation counts, step result type and lead decode functions.
package utf8d_pkg;

  localparam int ByteW  = 8;
  localparam int AfterW = 2;
  localparam int CpW    = 21;
  localparam int CntW   = 2;

  // Number of continuation bytes a lead byte calls for; none also marks an invalid lead.
  localparam logic [CntW-1:0] NeedNone  = 2'd0;
  localparam logic [CntW-1:0] NeedOne   = 2'd1;
  localparam logic [CntW-1:0] NeedTwo   = 2'd2;
  localparam logic [CntW-1:0] NeedThree = 2'd3;

  // Outcome of one byte: optional code point and the next decoder state.
  typedef struct packed {
    logic            emit;
    logic [CpW-1:0]  code_point;
    logic [CntW-1:0] pending;
    logic [CpW-1:0]  accum;
  } step_t;

  // Continuation bytes needed after a lead byte of 0x80 or above.
  function automatic logic [CntW-1:0] lead_need(input logic [ByteW-1:0] b);
    logic [CntW-1:0] need;
    unique case (b) inside
      [8'hC0:8'hDF]: need = NeedOne;
      [8'hE0:8'hEF]: need = NeedTwo;
      [8'hF0:8'hF7]: need = NeedThree;
      default:       need = NeedNone;
    endcase
    return need;
  endfunction

  // Payload bits carried by a lead byte, zero extended to a code point.
  function automatic logic [CpW-1:0] lead_bits(input logic [ByteW-1:0] b);
    logic [CpW-1:0] bits;
    unique case (b) inside
      [8'hC0:8'hDF]: bits = {{(CpW-5){1'b0}}, b[4:0]};
      [8'hE0:8'hEF]: bits = {{(CpW-4){1'b0}}, b[3:0]};
      [8'hF0:8'hF7]: bits = {{(CpW-3){1'b0}}, b[2:0]};
      default:       bits = '0;
    endcase
    return bits;
  endfunction

endpackage

>>> src/utf8d_step.sv
// Combinational decode of one byte against the current sequence state.
module utf8d_step (
  input  logic [utf8d_pkg::CntW-1:0]   pending_i,
  input  logic [utf8d_pkg::CpW-1:0]    accum_i,
  input  logic [utf8d_pkg::ByteW-1:0]  byte_i,
  input  logic [utf8d_pkg::AfterW-1:0] after_i,
  output utf8d_pkg::step_t             step_o
);

  logic [utf8d_pkg::CpW-1:0]  shifted;
  logic [utf8d_pkg::CntW-1:0] need;

  // Append the low six bits of a continuation byte.
  assign shifted = {accum_i[utf8d_pkg::CpW-7:0], byte_i[5:0]};
  assign need    = utf8d_pkg::lead_need(byte_i);

  // Continuation, ASCII, invalid or truncated lead, or start of a sequence.
  always_comb begin
    step_o            = '0;
    step_o.pending    = pending_i;
    step_o.accum      = accum_i;
    if (pending_i != utf8d_pkg::NeedNone) begin
      step_o.pending = pending_i - 1'b1;
      if (pending_i == utf8d_pkg::NeedOne) begin
        step_o.emit       = 1'b1;
        step_o.code_point = shifted;
        step_o.accum      = '0;
      end else begin
        step_o.accum = shifted;
      end
    end else if (!byte_i[utf8d_pkg::ByteW-1]) begin
      step_o.emit       = 1'b1;
      step_o.code_point = {{(utf8d_pkg::CpW-utf8d_pkg::ByteW){1'b0}}, byte_i};
    end else if ((need == utf8d_pkg::NeedNone) || (after_i < need)) begin
      step_o.emit       = 1'b1;
      step_o.code_point = '0;
    end else begin
      step_o.accum   = utf8d_pkg::lead_bits(byte_i);
      step_o.pending = need;
    end
  end

endmodule

>>> src/utf8_byte_stream_decoder_core.sv
// An accepted byte passes the input register, then the output register, before reaching out_*.
// Throughput: one byte per cycle unless out_stall holds a full output register; the input
// register feeds the decode logic and the output register, and the sequence state updates in
// the same cycle a byte leaves the input register. Non-final bytes of a sequence give no output.
// Reset (synchronous, rst_n low) empties both registers and returns the decoder to idle.
module utf8_byte_stream_decoder_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [utf8d_pkg::ByteW-1:0]   in_byte,
  input  logic [utf8d_pkg::AfterW-1:0]  in_bytes_after,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [utf8d_pkg::CpW-1:0]     out_code_point
);

  logic                          s1_valid_r, s1_valid_nxt;
  logic [utf8d_pkg::ByteW-1:0]   s1_byte_r, s1_byte_nxt;
  logic [utf8d_pkg::AfterW-1:0]  s1_after_r, s1_after_nxt;
  logic [utf8d_pkg::CntW-1:0]    pending_r, pending_nxt;
  logic [utf8d_pkg::CpW-1:0]     accum_r, accum_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [utf8d_pkg::CpW-1:0]     out_code_point_r, out_code_point_nxt;
  logic                          out_free;
  logic                          s1_go;
  utf8d_pkg::step_t              step;

  // The output register can take a new transaction when empty or being drained.
  assign out_free = !out_valid_r || !out_stall;
  assign s1_go    = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;

  utf8d_step u_step (
    .pending_i (pending_r),
    .accum_i   (accum_r),
    .byte_i    (s1_byte_r),
    .after_i   (s1_after_r),
    .step_o    (step)
  );

  // Next values for the input register, sequence state and output register.
  always_comb begin
    s1_valid_nxt       = s1_valid_r;
    s1_byte_nxt        = s1_byte_r;
    s1_after_nxt       = s1_after_r;
    pending_nxt        = pending_r;
    accum_nxt          = accum_r;
    out_valid_nxt      = out_valid_r;
    out_code_point_nxt = out_code_point_r;
    if (!in_stall) begin
      s1_valid_nxt = in_valid;
      s1_byte_nxt  = in_byte;
      s1_after_nxt = in_bytes_after;
    end
    if (s1_go) begin
      pending_nxt = step.pending;
      accum_nxt   = step.accum;
    end
    if (out_free) begin
      out_valid_nxt = s1_go && step.emit;
      if (s1_go && step.emit) begin
        out_code_point_nxt = step.code_point;
      end
    end
  end

  // Control and sequence state are cleared by reset; payload registers are not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      pending_r   <= utf8d_pkg::NeedNone;
      accum_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      pending_r   <= pending_nxt;
      accum_r     <= accum_nxt;
      out_valid_r <= out_valid_nxt;
    end
    s1_byte_r        <= s1_byte_nxt;
    s1_after_r       <= s1_after_nxt;
    out_code_point_r <= out_code_point_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_code_point = out_code_point_r;

  // The accumulator is empty whenever no sequence is open.
  a_idle_accum_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (pending_r == utf8d_pkg::NeedNone) |-> (accum_r == '0))
    else $error("accumulator not empty while idle");

  // A partial value never holds more bits than the bytes seen so far allow.
  a_accum_three: assert property (@(posedge clk) disable iff (!rst_n)
    (pending_r == utf8d_pkg::NeedThree) |-> (accum_r[utf8d_pkg::CpW-1:3] == '0))
    else $error("partial value too wide with three bytes pending");

  a_accum_two: assert property (@(posedge clk) disable iff (!rst_n)
    (pending_r == utf8d_pkg::NeedTwo) |-> (accum_r[utf8d_pkg::CpW-1:9] == '0))
    else $error("partial value too wide with two bytes pending");

  a_accum_one: assert property (@(posedge clk) disable iff (!rst_n)
    (pending_r == utf8d_pkg::NeedOne) |-> (accum_r[utf8d_pkg::CpW-1:15] == '0))
    else $error("partial value too wide with one byte pending");

  // An ASCII byte seen while idle comes out unchanged in the next cycle.
  a_ascii_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && (pending_r == utf8d_pkg::NeedNone) && !s1_byte_r[utf8d_pkg::ByteW-1])
    |=> (out_valid_r && (out_code_point_r[utf8d_pkg::ByteW-1:0] == $past(s1_byte_r))
         && (out_code_point_r[utf8d_pkg::CpW-1:utf8d_pkg::ByteW] == '0)))
    else $error("ASCII byte not passed through");

endmodule

>>> tb/tb.sv
// Self-checking testbench for the UTF-8 byte stream decoder core.
`timescale 1ns / 1ps

module tb;

  // Widths and sequence lengths taken from the shared package.
  localparam int ByteW  = utf8d_pkg::ByteW;
  localparam int AfterW = utf8d_pkg::AfterW;
  localparam int CpW    = utf8d_pkg::CpW;
  localparam int CntW   = utf8d_pkg::CntW;

  localparam logic [CntW-1:0] NeedNone  = utf8d_pkg::NeedNone;
  localparam logic [CntW-1:0] NeedOne   = utf8d_pkg::NeedOne;
  localparam logic [CntW-1:0] NeedTwo   = utf8d_pkg::NeedTwo;
  localparam logic [CntW-1:0] NeedThree = utf8d_pkg::NeedThree;

  localparam int RandItems  = 1250;
  localparam int CycleLimit = 400000;
  localparam int DirRows    = 25;

  // Lead byte classes: mask and match value for 2-, 3- and 4-byte sequences.
  localparam logic [ByteW-1:0] TwoByteMask   = 8'hE0;
  localparam logic [ByteW-1:0] TwoByteLead   = 8'hC0;
  localparam logic [ByteW-1:0] ThreeByteMask = 8'hF0;
  localparam logic [ByteW-1:0] ThreeByteLead = 8'hE0;
  localparam logic [ByteW-1:0] FourByteMask  = 8'hF8;
  localparam logic [ByteW-1:0] FourByteLead  = 8'hF0;
  localparam logic [ByteW-1:0] ContLead      = 8'h80;

  // One row of the directed table; typed marks a hand-written expected code point.
  typedef struct packed {
    logic [ByteW-1:0]  b;
    logic [AfterW-1:0] after;
    logic              typed;
    logic [CpW-1:0]    cp;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [ByteW-1:0]  in_byte = '0;
  logic [AfterW-1:0] in_bytes_after = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [CpW-1:0]    out_code_point;

  // Predictor state and the code points still owed by the block.
  logic [CntW-1:0] dec_pending = NeedNone;
  logic [CpW-1:0]  dec_accum = '0;
  logic [CpW-1:0]  pending_code_points[$];
  logic [CpW-1:0]  want_cp;
  int              fails = 0;
  int              cycles = 0;
  int              rand_sent = 0;
  bit              calm = 1'b0;

  dir_row_t dir_rows [DirRows] = '{
    '{8'h00, 2'd0, 1'b1, 21'h000000},  // smallest ASCII byte
    '{8'h7F, 2'd3, 1'b1, 21'h00007F},  // largest ASCII byte
    '{8'h80, 2'd3, 1'b1, 21'h000000},  // stray continuation as lead
    '{8'hBF, 2'd0, 1'b1, 21'h000000},
    '{8'hF8, 2'd3, 1'b1, 21'h000000},  // lead bytes beyond 4-byte form
    '{8'hFF, 2'd3, 1'b1, 21'h000000},
    '{8'hC0, 2'd0, 1'b1, 21'h000000},  // truncated leads, one short each
    '{8'hE0, 2'd1, 1'b1, 21'h000000},
    '{8'hF0, 2'd2, 1'b1, 21'h000000},
    '{8'hC3, 2'd1, 1'b0, 21'h0},       // two-byte sequence
    '{8'hA9, 2'd0, 1'b0, 21'h0},
    '{8'hE2, 2'd2, 1'b0, 21'h0},       // three-byte sequence
    '{8'h82, 2'd1, 1'b0, 21'h0},
    '{8'hAC, 2'd0, 1'b0, 21'h0},
    '{8'hF7, 2'd3, 1'b0, 21'h0},       // largest value the decoder can build
    '{8'hFF, 2'd3, 1'b0, 21'h0},
    '{8'hFF, 2'd3, 1'b0, 21'h0},
    '{8'hFF, 2'd3, 1'b1, 21'h1FFFFF},
    '{8'hDF, 2'd3, 1'b0, 21'h0},       // continuation without the 10 prefix
    '{8'h00, 2'd0, 1'b0, 21'h0},
    '{8'hF0, 2'd3, 1'b0, 21'h0},       // bytes_after ignored inside a sequence
    '{8'h90, 2'd0, 1'b0, 21'h0},
    '{8'h80, 2'd0, 1'b0, 21'h0},
    '{8'h80, 2'd0, 1'b0, 21'h0},
    '{8'h7F, 2'd0, 1'b1, 21'h00007F}
  };

  utf8_byte_stream_decoder_core i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .in_bytes_after (in_bytes_after),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_code_point (out_code_point)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Decode one byte; returns 1 when the byte yields a code point (zero for an invalid or truncated lead).
  function automatic logic decode_byte(input logic [ByteW-1:0] b,
                                       input logic [AfterW-1:0] after,
                                       output logic [CpW-1:0] cp);
    logic [CntW-1:0] need;
    logic [CpW-1:0]  bits;
    cp = '0;
    if (dec_pending != NeedNone) begin
      dec_accum   = {dec_accum[CpW-7:0], b[5:0]};
      dec_pending = dec_pending - 1'b1;
      if (dec_pending == NeedNone) begin
        cp        = dec_accum;
        dec_accum = '0;
        return 1'b1;
      end
      return 1'b0;
    end
    if (!b[7]) begin
      cp = {{(CpW-ByteW){1'b0}}, b};
      return 1'b1;
    end
    if ((b & TwoByteMask) == TwoByteLead) begin
      need = NeedOne;
      bits = {{(CpW-5){1'b0}}, b[4:0]};
    end else if ((b & ThreeByteMask) == ThreeByteLead) begin
      need = NeedTwo;
      bits = {{(CpW-4){1'b0}}, b[3:0]};
    end else if ((b & FourByteMask) == FourByteLead) begin
      need = NeedThree;
      bits = {{(CpW-3){1'b0}}, b[2:0]};
    end else begin
      return 1'b1;
    end
    // A lead with too few bytes behind it yields zero and leaves the decoder idle.
    if (after < need) return 1'b1;
    dec_accum   = bits;
    dec_pending = need;
    return 1'b0;
  endfunction

  // Random lead byte of the class that needs the given number of continuations.
  function automatic logic [ByteW-1:0] make_lead(input logic [CntW-1:0] need);
    logic [ByteW-1:0] r;
    r = ByteW'($urandom);
    case (need)
      NeedOne: make_lead = TwoByteLead | {3'b0, r[4:0]};
      NeedTwo: make_lead = ThreeByteLead | {4'b0, r[3:0]};
      default: make_lead = FourByteLead | {5'b0, r[2:0]};
    endcase
  endfunction

  // Continuation byte, mostly well formed with a random payload.
  function automatic logic [ByteW-1:0] make_cont();
    logic [ByteW-1:0] r;
    r = ByteW'($urandom);
    if ($urandom_range(0, 99) < 80) return ContLead | {2'b0, r[5:0]};
    return r;
  endfunction

  // Present one byte, hold it until accepted, and record what it should produce.
  task automatic send_byte(input logic [ByteW-1:0] b, input logic [AfterW-1:0] after,
                           input logic typed, input logic [CpW-1:0] typed_cp);
    logic [CpW-1:0] cp;
    while (!calm && $urandom_range(0, 99) < 26) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_byte        <= b;
    in_bytes_after <= after;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (decode_byte(b, after, cp))
      pending_code_points = {pending_code_points, (typed ? typed_cp : cp)};
    @(negedge clk);
  endtask

  // One random sequence: ASCII, well-formed multi-byte, truncated, invalid or noise.
  task automatic send_sequence();
    int              kind;
    logic [CntW-1:0] need;
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      send_byte(ByteW'($urandom_range(0, 127)), AfterW'($urandom), 1'b0, '0);
      rand_sent++;
    end else if (kind < 60) begin
      need = (kind < 30) ? NeedOne : (kind < 45) ? NeedTwo : NeedThree;
      send_byte(make_lead(need), AfterW'($urandom_range(need, 3)), 1'b0, '0);
      rand_sent++;
      for (int i = 0; i < need; i++) begin
        send_byte(make_cont(), AfterW'($urandom), 1'b0, '0);
        rand_sent++;
      end
    end else if (kind < 70) begin
      need = CntW'($urandom_range(1, 3));
      send_byte(make_lead(need), AfterW'($urandom_range(0, need - 1)), 1'b0, '0);
      rand_sent++;
    end else if (kind < 80) begin
      if ($urandom_range(0, 1) != 0)
        send_byte(ContLead | ByteW'($urandom_range(0, 63)), AfterW'($urandom), 1'b0, '0);
      else
        send_byte(FourByteMask | ByteW'($urandom_range(0, 7)), AfterW'($urandom), 1'b0, '0);
      rand_sent++;
    end else begin
      send_byte(ByteW'($urandom), AfterW'($urandom), 1'b0, '0);
      rand_sent++;
    end
  endtask

  // Result side stalls at random, except during the calm stretch.
  always @(negedge clk) begin
    out_stall <= (!calm && $urandom_range(0, 99) < 26);
  end

  // Check every result transaction against the oldest expected code point.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (pending_code_points.size() == 0) begin
        $error("code_point: expected none, got %h", out_code_point);
        fails++;
      end else begin
        want_cp = pending_code_points.pop_front();
        if (out_code_point !== want_cp) begin
          $error("code_point: expected %h, got %h", want_cp, out_code_point);
          fails++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table.
    for (int i = 0; i < DirRows; i++) begin
      send_byte(dir_rows[i].b, dir_rows[i].after, dir_rows[i].typed, dir_rows[i].cp);
    end

    // Random sequences, with a stretch where neither side idles.
    while (rand_sent < RandItems) begin
      calm = (rand_sent >= 500 && rand_sent < 750);
      send_sequence();
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    // Drain outstanding code points, then keep watching for strays.
    while (pending_code_points.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
